>>> hdl/png_unf_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
// Used by png_unf_pred and png_scanline_unfilter; no dependencies.
package png_unf_pkg;

   localparam int DATA_W     = 8;
   localparam int BPP_CSR_W  = 3;
   localparam int ROWB_CSR_W = 14;
   localparam int CSR_W      = 14;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_BPP  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWB = 1'd1;

   localparam logic [BPP_CSR_W-1:0]  BPP_RESET  = 3'd4;
   localparam logic [ROWB_CSR_W-1:0] ROWB_RESET = 14'd8192;

   localparam logic [DATA_W-1:0] FILT_MAX_CODE = 8'd4;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4,
      FILT_BAD   = 3'd5
   } filter_type;

   // left, above and above-left neighbors of the byte being rebuilt
   typedef struct packed {
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] c;
   } nbr_type;

endpackage

>>> hdl/png_unf_pred.sv
// Filter predictor and byte reconstruction (None, Sub, Up, Average, Paeth).
// Purely combinational; depends on png_unf_pkg.
module png_unf_pred
   import png_unf_pkg::*;
(
   input  filter_type        filter,
   input  nbr_type           nbr,
   input  logic [DATA_W-1:0] filt_byte,
   output logic [DATA_W-1:0] recon
);

   logic [DATA_W:0]   avg_sum;
   logic signed [DATA_W+1:0] sa, sb, sc;
   logic [DATA_W+1:0] pa, pb, pc;
   logic [DATA_W-1:0] paeth;
   logic [DATA_W-1:0] pred;

   function automatic logic [DATA_W+1:0] absval(input logic signed [DATA_W+1:0] v);
      absval = v[DATA_W+1] ? (DATA_W+2)'(0) - v : v;
   endfunction

   always_comb begin
      avg_sum = {1'b0, nbr.a} + {1'b0, nbr.b};
      sa = signed'({2'b00, nbr.a});
      sb = signed'({2'b00, nbr.b});
      sc = signed'({2'b00, nbr.c});
      pa = absval(sb - sc);
      pb = absval(sa - sc);
      pc = absval(sa + sb - sc - sc);
      if (pa <= pb && pa <= pc) begin
         paeth = nbr.a;
      end else if (pb <= pc) begin
         paeth = nbr.b;
      end else begin
         paeth = nbr.c;
      end
      case (filter)
         FILT_SUB:   pred = nbr.a;
         FILT_UP:    pred = nbr.b;
         FILT_AVG:   pred = avg_sum[DATA_W:1];
         FILT_PAETH: pred = paeth;
         default:    pred = '0;
      endcase
      recon = filt_byte + pred;
   end

endmodule

>>> hdl/png_scanline_unfilter.sv
// PNG scanline unfilter top level: row sequencing, line buffer, output register.
// Depends on png_unf_pkg and png_unf_pred.
// An accepted data byte is registered in stage 1, then in the output register that drives rsp_.
// Throughput: one byte per cycle unless rsp_tready stalls; filter-type bytes give no transaction.
// Reset is synchronous: control, neighbor registers and CSRs clear (bpp 4, row 8192 bytes);
// the line buffer is not cleared, the first row of an image reads zero above.
module png_scanline_unfilter
   import png_unf_pkg::*;
#(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 4
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // [7:0] data_byte
   input  logic                 req_tuser,   // [0] start_of_image
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // [7:0] pixel_byte
   output logic                 rsp_tlast,
   output logic                 rsp_tuser,   // [0] bad_filter
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int AW   = $clog2(MAX_ROW_BYTES);
   localparam int RBW  = $clog2(MAX_ROW_BYTES + 1);
   localparam int LW   = (RBW > ROWB_CSR_W) ? RBW : ROWB_CSR_W;
   localparam int BPW  = $clog2(MAX_PIXEL_BYTES + 1);
   localparam int CMPW = (BPW > BPP_CSR_W) ? BPW : BPP_CSR_W;
   localparam int SW   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   // CSRs
   logic [BPP_CSR_W-1:0]  bpp_ff;
   logic [ROWB_CSR_W-1:0] rowb_ff;

   // row sequencing
   logic          expect_ff;
   logic          first_ff;
   filter_type    filter_ff;
   logic [AW-1:0] col_ff;
   logic [SW-1:0] res_ff [MAX_PIXEL_BYTES];   // res_ff[k] = column mod (k+1)

   // stage 1
   logic          s1_valid_ff;
   logic [DATA_W-1:0] s1_data_ff;
   logic [AW-1:0] s1_col_ff;
   logic [SW-1:0] s1_slot_ff;
   logic          s1_aok_ff;
   logic          s1_first_ff;
   filter_type    s1_filter_ff;
   logic          s1_last_ff;
   logic [DATA_W-1:0] above_rd_ff;

   // neighbor history
   logic [DATA_W-1:0] left_ff  [MAX_PIXEL_BYTES];
   logic [DATA_W-1:0] aleft_ff [MAX_PIXEL_BYTES];

   // line buffer
   logic [DATA_W-1:0] line_mem [MAX_ROW_BYTES];

   // output register
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;
   logic              rsp_bad_ff;

   logic          req_fire;
   logic          s1_adv;
   logic          take_filter;
   logic [CMPW-1:0] bpp_raw;
   logic [CMPW-1:0] bpp_eff;
   logic [SW-1:0] bpp_idx;
   logic [LW-1:0] rb_ext;
   logic [LW-1:0] rb_eff;
   logic [LW-1:0] col_nx;
   logic          row_last;
   logic          aok;
   logic [SW-1:0] slot;
   filter_type    new_filter;
   nbr_type       nbr;
   logic [DATA_W-1:0] recon;

   always_comb begin
      s1_adv      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready  = !s1_valid_ff || s1_adv;
      req_fire    = req_tvalid && req_tready;
      take_filter = expect_ff || req_tuser;

      bpp_raw = CMPW'(bpp_ff);
      if (bpp_ff == '0) begin
         bpp_eff = CMPW'(1);
      end else if (bpp_raw > CMPW'(MAX_PIXEL_BYTES)) begin
         bpp_eff = CMPW'(MAX_PIXEL_BYTES);
      end else begin
         bpp_eff = bpp_raw;
      end
      bpp_idx = SW'(bpp_eff - CMPW'(1));
      slot    = res_ff[bpp_idx];
      aok     = col_ff >= AW'(bpp_eff);

      rb_ext = LW'(rowb_ff);
      if (rowb_ff == '0) begin
         rb_eff = LW'(1);
      end else if (rb_ext > LW'(MAX_ROW_BYTES)) begin
         rb_eff = LW'(MAX_ROW_BYTES);
      end else begin
         rb_eff = rb_ext;
      end
      col_nx   = LW'(col_ff) + LW'(1);
      row_last = col_nx >= rb_eff;

      new_filter = (req_tdata > FILT_MAX_CODE) ? FILT_BAD : filter_type'(req_tdata[2:0]);

      nbr.a = s1_aok_ff ? left_ff[s1_slot_ff] : '0;
      nbr.b = s1_first_ff ? '0 : above_rd_ff;
      nbr.c = (s1_aok_ff && !s1_first_ff) ? aleft_ff[s1_slot_ff] : '0;
   end

   png_unf_pred u_pred (
      .filter    (s1_filter_ff),
      .nbr       (nbr),
      .filt_byte (s1_data_ff),
      .recon     (recon)
   );

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff  <= BPP_RESET;
         rowb_ff <= ROWB_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BPP:  bpp_ff  <= csr_wdata[BPP_CSR_W-1:0];
            CSR_ROWB: rowb_ff <= csr_wdata[ROWB_CSR_W-1:0];
            default:  ;
         endcase
      end
   end

   // row sequencing, evaluated at acceptance
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= 1'b1;
         first_ff  <= 1'b1;
         filter_ff <= FILT_NONE;
         col_ff    <= '0;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            res_ff[k] <= '0;
         end
      end else if (req_fire) begin
         if (take_filter) begin
            filter_ff <= new_filter;
            expect_ff <= 1'b0;
            col_ff    <= '0;
            if (req_tuser) begin
               first_ff <= 1'b1;
            end
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               res_ff[k] <= '0;
            end
         end else if (row_last) begin
            expect_ff <= 1'b1;
            first_ff  <= 1'b0;
            col_ff    <= '0;
         end else begin
            col_ff <= col_nx[AW-1:0];
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               res_ff[k] <= (res_ff[k] == SW'(k)) ? '0 : res_ff[k] + SW'(1);
            end
         end
      end
   end

   // stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire && !take_filter) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (req_fire && !take_filter) begin
         s1_data_ff   <= req_tdata;
         s1_col_ff    <= col_ff;
         s1_slot_ff   <= slot;
         s1_aok_ff    <= aok;
         s1_first_ff  <= first_ff;
         s1_filter_ff <= filter_ff;
         s1_last_ff   <= row_last;
      end
   end

   // line buffer: read ahead at acceptance, write back the rebuilt byte
   always_ff @(posedge clock) begin
      if (req_fire) begin
         above_rd_ff <= line_mem[col_ff];
      end
      if (s1_adv) begin
         line_mem[s1_col_ff] <= recon;
      end
   end

   // neighbor history
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k]  <= '0;
            aleft_ff[k] <= '0;
         end
      end else if (s1_adv) begin
         left_ff[s1_slot_ff]  <= recon;
         aleft_ff[s1_slot_ff] <= nbr.b;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= recon;
         rsp_last_ff <= s1_last_ff;
         rsp_bad_ff  <= (s1_filter_ff == FILT_BAD);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

`ifndef SYNTHESIS
   // a filter-type byte never occupies stage 1
   a_filter_no_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire && take_filter |=> !s1_valid_ff)
      else $error("filter byte left stage 1 occupied");

   // column counter sits at zero while waiting for a filter-type byte
   a_col_idle: assert property (@(posedge clock) disable iff (reset)
      expect_ff |-> col_ff == '0)
      else $error("column count nonzero at row start");

   // every accepted data byte lands in stage 1
   a_data_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire && !take_filter |=> s1_valid_ff)
      else $error("data byte lost before stage 1");

   // stage 1 hand-off always produces a response
   a_s1_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_tvalid)
      else $error("stage 1 advanced without response");
`endif

endmodule

>>> test/tb_png_scanline_unfilter.sv
// Self-checking testbench for png_scanline_unfilter: random stream traffic with stalls on
// both sides, a behavioral unfilter predictor and an in-order pixel scoreboard.
// Depends on png_unf_pkg and the png_scanline_unfilter RTL only.
module tb_png_scanline_unfilter;
   import png_unf_pkg::*;

   localparam int ROW_MAX = 8192;
   localparam int PIX_MAX = 4;

   typedef struct packed {
      logic [7:0] pix;
      logic       last;
      logic       bad;
   } pixel_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   // {start_of_image, data_byte} waiting to be sent
   logic [8:0] stream_q[$];
   pixel_type  pixel_q[$];

   int send_idle = 6;
   int recv_idle = 68;
   int n_err = 0, n_in = 0, n_pix = 0, n_rows = 0, n_badpix = 0, n_csr = 0;

   // predictor state
   logic [7:0]      line_q [0:ROW_MAX-1];
   logic [7:0]      left_q [0:PIX_MAX-1] = '{default: 8'h00};
   logic [7:0]      upleft_q [0:PIX_MAX-1] = '{default: 8'h00};
   int unsigned     col_q = 0;
   filter_type      filt_q = FILT_NONE;
   logic            want_filter = 1'b1;
   logic            top_row = 1'b1;
   logic [2:0]      cfg_bpp = BPP_RESET;
   logic [13:0]     cfg_rowb = ROWB_RESET;

   // stimulus-side row tracking, keeps reads of the line buffer inside written columns
   int   g_col = 0;
   int   g_hwm = 0;
   logic g_want = 1'b1;
   logic g_top = 1'b1;

   png_scanline_unfilter dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] paeth_pick(input logic [7:0] a, b, c);
      int ia, ib, ic, pa, pb, pc;
      ia = a;
      ib = b;
      ic = c;
      pa = (ib > ic) ? ib - ic : ic - ib;
      pb = (ia > ic) ? ia - ic : ic - ia;
      pc = (ia + ib > 2 * ic) ? ia + ib - 2 * ic : 2 * ic - ia - ib;
      if (pa <= pb && pa <= pc)
         return a;
      if (pb <= pc)
         return b;
      return c;
   endfunction

   task automatic unfilter_byte(input logic [7:0] d, input logic sof);
      int unsigned bpp, rb, c, slot;
      logic [7:0]  a, b, ul, pred;
      logic [8:0]  sum;
      pixel_type   px;
      if (sof) begin
         top_row = 1'b1;
         want_filter = 1'b1;
      end
      if (want_filter) begin
         filt_q = (d > FILT_MAX_CODE) ? FILT_BAD : filter_type'(d[2:0]);
         col_q = 0;
         want_filter = 1'b0;
      end else begin
         bpp = (cfg_bpp == 0) ? 1 : (cfg_bpp > PIX_MAX) ? PIX_MAX : cfg_bpp;
         rb = (cfg_rowb == 0) ? 1 : (cfg_rowb > ROW_MAX) ? ROW_MAX : cfg_rowb;
         c = (col_q >= ROW_MAX) ? ROW_MAX - 1 : col_q;
         slot = c % bpp;
         a = (c >= bpp) ? left_q[slot] : 8'h00;
         b = top_row ? 8'h00 : line_q[c];
         ul = (c >= bpp && !top_row) ? upleft_q[slot] : 8'h00;
         sum = a + b;
         case (filt_q)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum[8:1];
            FILT_PAETH: pred = paeth_pick(a, b, ul);
            default:    pred = 8'h00;
         endcase
         px.pix = d + pred;
         upleft_q[slot] = b;
         left_q[slot] = px.pix;
         line_q[c] = px.pix;
         px.last = (c + 1 >= rb);
         px.bad = (filt_q == FILT_BAD);
         if (px.last) begin
            want_filter = 1'b1;
            top_row = 1'b0;
            col_q = 0;
         end else begin
            col_q = c + 1;
         end
         pixel_q.push_back(px);
      end
   endtask

   task automatic push_stream_byte(input logic [7:0] d, input logic sof);
      int rb;
      rb = (cfg_rowb == 0) ? 1 : (cfg_rowb > ROW_MAX) ? ROW_MAX : cfg_rowb;
      // row grew past anything written: restart the image instead of reading stale buffer
      if (!sof && !g_want && !g_top && g_col >= g_hwm)
         sof = 1'b1;
      if (sof) begin
         g_top = 1'b1;
         g_want = 1'b1;
      end
      if (g_want) begin
         g_col = 0;
         g_want = 1'b0;
      end else begin
         if (g_col + 1 > g_hwm)
            g_hwm = g_col + 1;
         if (g_col + 1 >= rb) begin
            g_want = 1'b1;
            g_top = 1'b0;
            g_col = 0;
         end else begin
            g_col++;
         end
      end
      stream_q.push_back({sof, d});
   endtask

   task automatic gen_stream(input int n);
      logic [7:0] d;
      logic       sof;
      repeat (n) begin
         if (g_want) begin
            sof = ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 11) == 0)
               d = ($urandom_range(0, 3) == 0) ? 8'd5 : 8'($urandom_range(5, 255));
            else
               d = 8'($urandom_range(0, 4));
         end else begin
            sof = ($urandom_range(0, 99) == 0);
            case ($urandom_range(0, 9))
               0:       d = 8'h00;
               1:       d = 8'hFF;
               default: d = 8'($urandom_range(0, 255));
            endcase
         end
         push_stream_byte(d, sof);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BPP)
         cfg_bpp = val[2:0];
      else
         cfg_rowb = val[13:0];
      n_csr++;
   endtask

   // all items sent, all pixels back, plus pipeline slack for a trailing filter byte
   task automatic wait_idle();
      while (stream_q.size() != 0 || req_tvalid || pixel_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            unfilter_byte(req_tdata, req_tuser);
            n_in++;
         end
         if (!req_tvalid || req_tready) begin
            if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               {req_tuser, req_tdata} <= stream_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_q.size() == 0) begin
               n_err++;
               $display("%0t: unexpected pixel transaction: data %h last %b bad %b", $time,
                        rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               if (rsp_tdata !== pixel_q[0].pix || rsp_tlast !== pixel_q[0].last ||
                   rsp_tuser !== pixel_q[0].bad) begin
                  n_err++;
                  $display("%0t: pixel mismatch: expected data %h last %b bad %b, got %h %b %b",
                           $time, pixel_q[0].pix, pixel_q[0].last, pixel_q[0].bad,
                           rsp_tdata, rsp_tlast, rsp_tuser);
               end
               n_pix++;
               if (pixel_q[0].last)
                  n_rows++;
               if (pixel_q[0].bad)
                  n_badpix++;
               void'(pixel_q.pop_front());
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   initial begin
      #(12 * 2_000_000);
      $display("FAIL png_scanline_unfilter");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: every filter type on a 2-bpp, 3-byte row, wraparound and extremes
      write_reg(CSR_BPP, 14'd2);
      write_reg(CSR_ROWB, 14'd3);
      push_stream_byte(8'd0, 1'b1);
      push_stream_byte(8'h00, 1'b0);
      push_stream_byte(8'hFF, 1'b0);
      push_stream_byte(8'h80, 1'b0);
      push_stream_byte(8'd1, 1'b0);
      push_stream_byte(8'hFF, 1'b0);
      push_stream_byte(8'h01, 1'b0);
      push_stream_byte(8'h10, 1'b0);
      push_stream_byte(8'd2, 1'b0);
      push_stream_byte(8'h01, 1'b0);
      push_stream_byte(8'hFF, 1'b0);
      push_stream_byte(8'h80, 1'b0);
      push_stream_byte(8'd3, 1'b0);
      push_stream_byte(8'hFF, 1'b0);
      push_stream_byte(8'hFF, 1'b0);
      push_stream_byte(8'hFF, 1'b0);
      push_stream_byte(8'd4, 1'b0);
      push_stream_byte(8'h10, 1'b0);
      push_stream_byte(8'h20, 1'b0);
      push_stream_byte(8'hF0, 1'b0);
      push_stream_byte(8'hFF, 1'b0);
      push_stream_byte(8'hAB, 1'b0);
      push_stream_byte(8'hCD, 1'b0);
      push_stream_byte(8'hEF, 1'b0);
      wait_idle();

      // random phases; stream state carries across, so settings also change mid-row
      for (int p = 0; p < 12; p++) begin
         if (p < 4) begin
            send_idle = 6;
            recv_idle = 68;
         end else if (p < 8) begin
            send_idle = 68;
            recv_idle = 6;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         case (p)
            0: begin
               write_reg(CSR_BPP, 14'd1);
               write_reg(CSR_ROWB, 14'd1);
            end
            1: begin
               write_reg(CSR_BPP, 14'd0);
               write_reg(CSR_ROWB, 14'd0);
            end
            2: begin
               write_reg(CSR_BPP, 14'd7);
               write_reg(CSR_ROWB, 14'd5);
            end
            3: begin
               write_reg(CSR_BPP, 14'd4);
               write_reg(CSR_ROWB, 14'd300);
            end
            default: begin
               write_reg(CSR_BPP, 14'($urandom_range(0, 7)));
               case ($urandom_range(0, 9))
                  0:       write_reg(CSR_ROWB, 14'($urandom_range(0, 1)));
                  1:       write_reg(CSR_ROWB, 14'($urandom_range(100, 400)));
                  default: write_reg(CSR_ROWB, 14'($urandom_range(2, 24)));
               endcase
            end
         endcase
         gen_stream(105);
         wait_idle();
      end

      // row length above the limit clamps to 8192: a new image with a partial Paeth row
      write_reg(CSR_BPP, 14'd3);
      write_reg(CSR_ROWB, 14'd16383);
      push_stream_byte(8'd4, 1'b1);
      repeat (40) push_stream_byte(8'($urandom_range(0, 255)), 1'b0);
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Covered %0d input transactions, %0d pixels over %0d rows (%0d bad-filter pixels).",
               n_in, n_pix, n_rows, n_badpix);
      $display("%0d register writes, pixel sizes 0..7, row lengths 0..16383, %0d mismatches.",
               n_csr, n_err);
      if (n_err == 0)
         $display("PASS png_scanline_unfilter");
      else
         $display("FAIL png_scanline_unfilter");
      $finish;
   end

endmodule
